@@ sv/fpba_pkg.sv @@
// Shared constants, types and reset values for the fit-policy block allocator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int BLOCK_UNIT = 100;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int AMT_W      = 16;
  localparam int MODE_W     = 2;
  localparam int BLK_W      = 5;
  localparam int AMT_MAX    = 65535;

  // Input beat: tdata = request_size, tuser = mode
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = MODE_W;
  // Output beat: tdata = block_number, free_left, allotted_now (37 bits, padded)
  localparam int M_TDATA_W  = 40;
  localparam int M_TUSER_W  = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEST  = 2'd0,
    MODE_WORST = 2'd1,
    MODE_FIRST = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;    // capture request, restart scan
    logic scan;    // examine one block
    logic commit;  // write back and load result register
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

  function automatic logic [AMT_W-1:0] init_free(input int k);
    int v;
    v = (k + 1) * BLOCK_UNIT;
    if (v > AMT_MAX) v = AMT_MAX;
    return v[AMT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/fpba_ctrl.sv @@
// Controller FSM for the allocator: sequences accept, scan and write-back.
// Owns the output valid flag. Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpba_ctrl
  import fpba_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dp_cmd_t         cmd_o,
  input  wire dp_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result slot can take a new beat if empty or draining this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan  = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/fpba_dp.sv @@
// Datapath for the allocator: block tables, one-block-per-cycle fit scan,
// write-back of the chosen block and the result register. Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpba_dp
  import fpba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_status_t             status_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [AMT_W-1:0]  size_i,
  output logic                   granted_o,
  output logic [BLK_W-1:0]       block_number_o,
  output logic [AMT_W-1:0]       free_left_o,
  output logic [AMT_W-1:0]       allotted_now_o
);

  logic [AMT_W-1:0]  free_q  [NUM_BLOCKS];
  logic [AMT_W-1:0]  allot_q [NUM_BLOCKS];

  logic [IDX_W-1:0]  idx_q, idx_d;
  mode_e             mode_q;
  logic [AMT_W-1:0]  size_q;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  sel_idx_q, sel_idx_d;
  logic [AMT_W-1:0]  sel_free_q, sel_free_d;
  logic [AMT_W-1:0]  sel_allot_q, sel_allot_d;

  logic              res_granted_q;
  logic [BLK_W-1:0]  res_blk_q;
  logic [AMT_W-1:0]  res_free_q, res_allot_q;

  logic [AMT_W-1:0]  cur_free;
  logic              fits, take;
  logic [AMT_W-1:0]  new_free;
  logic [AMT_W:0]    allot_sum;
  logic [AMT_W-1:0]  new_allot;
  logic [IDX_W:0]    blk_num;

  assign cur_free           = free_q[idx_q];
  assign fits               = cur_free >= size_q;
  assign status_o.scan_last = idx_q == IDX_W'(NUM_BLOCKS - 1);

  always_comb begin
    take = 1'b0;
    case (mode_q)
      MODE_BEST:  take = fits && (!found_q || cur_free < sel_free_q);
      MODE_WORST: take = fits && (!found_q || cur_free >= sel_free_q);
      MODE_FIRST: take = fits && !found_q;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    found_d     = found_q;
    sel_idx_d   = sel_idx_q;
    sel_free_d  = sel_free_q;
    sel_allot_d = sel_allot_q;
    if (cmd_i.load) begin
      idx_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.scan) begin
      idx_d = idx_q + 1'b1;
      if (take) begin
        found_d     = 1'b1;
        sel_idx_d   = idx_q;
        sel_free_d  = cur_free;
        sel_allot_d = allot_q[idx_q];
      end
    end
  end

  // allotted amount saturates at full scale
  assign new_free  = sel_free_q - size_q;
  assign allot_sum = {1'b0, sel_allot_q} + {1'b0, size_q};
  assign new_allot = allot_sum[AMT_W] ? AMT_W'(AMT_MAX) : allot_sum[AMT_W-1:0];
  assign blk_num   = {1'b0, sel_idx_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        free_q[k]  <= init_free(k);
        allot_q[k] <= '0;
      end
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      found_q <= found_d;
      if (cmd_i.commit && found_q) begin
        free_q[sel_idx_q]  <= new_free;
        allot_q[sel_idx_q] <= new_allot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_idx_q   <= sel_idx_d;
    sel_free_q  <= sel_free_d;
    sel_allot_q <= sel_allot_d;
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      size_q <= size_i;
    end
    if (cmd_i.commit) begin
      res_granted_q <= found_q;
      res_blk_q     <= found_q ? BLK_W'(blk_num) : '0;
      res_free_q    <= found_q ? new_free : '0;
      res_allot_q   <= found_q ? new_allot : '0;
    end
  end

  assign granted_o      = res_granted_q;
  assign block_number_o = res_blk_q;
  assign free_left_o    = res_free_q;
  assign allotted_now_o = res_allot_q;

endmodule

`default_nettype wire

@@ sv/fit_policy_block_allocator.sv @@
// Fit-policy block allocator: best, worst or first fit over NUM_BLOCKS blocks.
// Each request is accepted, scanned one block per cycle, then written back.
// A new request is taken only after the previous one is written back.
// The result register lets the next request start while a result waits.
// Reset (async, active low) restores all block tables to their initial amounts.
// Depends on fpba_pkg, fpba_ctrl and fpba_dp.
`timescale 1ns / 1ps
`default_nettype none

module fit_policy_block_allocator
  import fpba_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] request_size
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] mode
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,  // [4:0] block_number, [20:5] free_left,
                                                   // [36:21] allotted_now, [39:37] zero
  output logic [M_TUSER_W-1:0]      m_axis_tuser   // [0] granted
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             granted;
  logic [BLK_W-1:0] block_number;
  logic [AMT_W-1:0] free_left;
  logic [AMT_W-1:0] allotted_now;

  fpba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  fpba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (s_axis_tuser[MODE_W-1:0]),
    .size_i         (s_axis_tdata[AMT_W-1:0]),
    .granted_o      (granted),
    .block_number_o (block_number),
    .free_left_o    (free_left),
    .allotted_now_o (allotted_now)
  );

  assign m_axis_tdata = {3'b000, allotted_now, free_left, block_number};
  assign m_axis_tuser = granted;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for fit_policy_block_allocator: best, worst and first fit
// requests against an in-bench allocation model, with random idling on both sides.
// Depends on fpba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
  import fpba_pkg::*;

  localparam int N_RANDOM = 1030;
  localparam int CALM_LO  = 6000;   // cycle window with no idling on either side
  localparam int CALM_HI  = 10000;
  localparam int DRAIN_AT = 600;    // sender waits for all results once this many requests are sent
  localparam int HOLD_AT  = 200;    // long receiver hold-off starts after this many results
  localparam int HOLD_LEN = 400;

  typedef struct {
    mode_e            mode;
    logic [AMT_W-1:0] size;
  } alloc_req_t;

  typedef struct {
    logic             granted;
    logic [BLK_W-1:0] block_no;
    logic [AMT_W-1:0] free_left;
    logic [AMT_W-1:0] allotted_now;
  } alloc_res_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [15:0] request_size
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // [1:0] mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [4:0] block_number, [20:5] free_left,
                                             // [36:21] allotted_now
  logic [M_TUSER_W-1:0] m_axis_tuser;        // [0] granted

  alloc_req_t       req_q[$];
  alloc_res_t       grant_q[$];
  logic [AMT_W-1:0] free_amt  [NUM_BLOCKS];
  logic [AMT_W-1:0] allot_amt [NUM_BLOCKS];

  alloc_req_t drv_req;
  alloc_res_t got_res;
  alloc_res_t exp_res;
  bit         in_beat;
  int         cyc;
  int         n_sent;
  int         n_results;
  int         n_fail;
  int         hold_left;
  bit         held_once;

  wire calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

  fit_policy_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Allocation model: picks a block by policy, charges it, returns the result beat.
  function automatic alloc_res_t place_request(input alloc_req_t rq);
    alloc_res_t r;
    int         pick;
    logic [AMT_W:0] sum;
    r    = '{granted: 1'b0, block_no: '0, free_left: '0, allotted_now: '0};
    pick = -1;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      if (free_amt[k] >= rq.size) begin
        case (rq.mode)
          MODE_FIRST: if (pick < 0) pick = k;
          MODE_BEST:  if (pick < 0 || free_amt[k] < free_amt[pick]) pick = k;
          MODE_WORST: if (pick < 0 || free_amt[k] >= free_amt[pick]) pick = k;
          default:    pick = -1;
        endcase
      end
    end
    if (pick >= 0) begin
      sum = {1'b0, allot_amt[pick]} + {1'b0, rq.size};
      if (sum > AMT_MAX) sum = (AMT_W+1)'(AMT_MAX);
      free_amt[pick]  = free_amt[pick] - rq.size;
      allot_amt[pick] = sum[AMT_W-1:0];
      r.granted       = 1'b1;
      r.block_no      = BLK_W'(pick + 1);
      r.free_left     = free_amt[pick];
      r.allotted_now  = allot_amt[pick];
    end
    return r;
  endfunction

  task automatic add_req(input mode_e m, input int sz);
    alloc_req_t rq;
    rq.mode = m;
    rq.size = sz[AMT_W-1:0];
    req_q.push_back(rq);
  endtask

  // Monitor: predicts on every input beat, checks every output beat.
  always @(posedge clk_i) begin
    cyc     <= cyc + 1;
    in_beat  = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_beat) begin
      drv_req.mode = mode_e'(s_axis_tuser);
      drv_req.size = s_axis_tdata[AMT_W-1:0];
      grant_q.push_back(place_request(drv_req));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results     = n_results + 1;
      got_res.granted      = m_axis_tuser[0];
      got_res.block_no     = m_axis_tdata[4:0];
      got_res.free_left    = m_axis_tdata[20:5];
      got_res.allotted_now = m_axis_tdata[36:21];
      if (grant_q.size() == 0) begin
        $error("unexpected result beat: granted %0d block %0d",
               got_res.granted, got_res.block_no);
        n_fail++;
      end else begin
        exp_res = grant_q.pop_front();
        if (got_res.granted !== exp_res.granted) begin
          $error("granted: expected %0d, got %0d", exp_res.granted, got_res.granted);
          n_fail++;
        end
        if (got_res.block_no !== exp_res.block_no) begin
          $error("block_number: expected %0d, got %0d", exp_res.block_no, got_res.block_no);
          n_fail++;
        end
        if (got_res.free_left !== exp_res.free_left) begin
          $error("free_left: expected %0d, got %0d", exp_res.free_left, got_res.free_left);
          n_fail++;
        end
        if (got_res.allotted_now !== exp_res.allotted_now) begin
          $error("allotted_now: expected %0d, got %0d",
                 exp_res.allotted_now, got_res.allotted_now);
          n_fail++;
        end
      end
    end
  end

  // Sender: offers queued requests, holds a beat until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beat) begin
      if (n_sent == DRAIN_AT && grant_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
        drv_req        = req_q.pop_front();
        s_axis_tdata  <= drv_req.size;
        s_axis_tuser  <= drv_req.mode;
        s_axis_tvalid <= 1'b1;
        n_sent         = n_sent + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off so the input backs up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!held_once && n_results >= HOLD_AT) begin
      held_once     <= 1'b1;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  initial begin
    int   r;
    int   sz;
    mode_e m;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      free_amt[k]  = AMT_W'(((k + 1) * BLOCK_UNIT > AMT_MAX) ? AMT_MAX : (k + 1) * BLOCK_UNIT);
      allot_amt[k] = '0;
    end

    // Directed: zero sizes, refusals, ties, exact fits, unused mode
    add_req(MODE_BEST,  0);
    add_req(MODE_WORST, 0);
    add_req(MODE_FIRST, 0);
    add_req(MODE_NONE,  10);
    add_req(MODE_BEST,  65535);
    add_req(MODE_WORST, 65535);
    add_req(MODE_FIRST, 65535);
    add_req(MODE_FIRST, 150);   // block 2 down to 50
    add_req(MODE_FIRST, 250);   // block 3 down to 50
    add_req(MODE_BEST,  40);    // blocks 2 and 3 tie: lower wins
    add_req(MODE_WORST, 100);   // block 16 down to 1500, ties with 15
    add_req(MODE_WORST, 0);     // tie on the largest: higher wins
    add_req(MODE_BEST,  1500);  // exact fit
    add_req(MODE_FIRST, 1500);  // exact fit on the other one
    add_req(MODE_WORST, 1401);  // nothing that large left
    add_req(MODE_NONE,  0);
    add_req(MODE_NONE,  65535);
    add_req(MODE_WORST, 16'h8000);
    add_req(MODE_FIRST, 16'h7fff);
    add_req(MODE_BEST,  1);

    for (int i = 0; i < N_RANDOM; i++) begin
      r  = $urandom_range(99);
      m  = (r < 5) ? MODE_NONE : mode_e'($urandom_range(2));
      r  = $urandom_range(99);
      if (r < 10)      sz = $urandom_range(65535);
      else if (r < 20) sz = 0;
      else if (r < 35) sz = $urandom_range(400);
      else             sz = $urandom_range(31);
      add_req(m, sz);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
